FILE: design/lowest_free_node_allocator_core_defines.svh
// Assertion macros used by the allocator top level.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef LOWEST_FREE_NODE_ALLOCATOR_CORE_DEFINES_SVH
`define LOWEST_FREE_NODE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LFNA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LFNA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lfna_pkg.sv
// Types and constants of the lowest-free node allocator.
// No dependencies; used by the datapath, the controller and the top level.
package lfna_pkg;

  localparam int WORD_W = 32;  // bitmap row width
  localparam int OFS_W  = 5;   // bit offset within a row
  localparam int ID_W   = 10;  // node id field width
  localparam int CNT_W  = 11;  // node count register width

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_t;

  typedef struct packed {
    op_t             opcode;
    logic [ID_W-1:0] node_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    status_t         status;
    logic [ID_W-1:0] top_mark;
    logic            hint_valid;
    logic [ID_W-1:0] hint_id;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;  // write one row of the reset sweep
    logic start;     // capture an input transaction
    logic rd;        // read the current bitmap row
    logic eval;      // row data valid: update state
    logic finish;    // load the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // sweep is on its last row
    logic more;      // scan continues with the next row
  } dp_sts_t;

endpackage

FILE: design/lfna_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfna_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: design/lfna_datapath.sv
// Allocator datapath: bitmap RAM, hint, high-water mark, row scan, result.
// Depends on lfna_pkg and lfna_ram.
module lfna_datapath #(
  parameter int NODES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lfna_pkg::dp_cmd_t         cmd,
  output lfna_pkg::dp_sts_t         sts,
  input  lfna_pkg::in_item_t        in_data,
  input  logic                      cfg_we,
  input  logic [lfna_pkg::CNT_W-1:0] cfg_data,
  output lfna_pkg::out_item_t       out_data
);
  import lfna_pkg::*;

  localparam int ROWS = (NODES + WORD_W - 1) / WORD_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW   = RW + OFS_W;
  localparam int EW   = (XW + 1 > CNT_W) ? XW + 1 : CNT_W;
  localparam int SW   = OFS_W + 1;

  // control state
  logic [CNT_W-1:0] count_cfg_r, count_cfg_nxt;
  logic [XW-1:0]    hw_r, hw_nxt;
  logic [XW-1:0]    hint_r, hint_nxt;
  logic             hint_vld_r, hint_vld_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             first_r, first_nxt;
  // per-transaction payload
  op_t              op_r, op_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             hmode_r, hmode_nxt;
  logic [XW-1:0]    grant_r, grant_nxt;
  logic [XW-1:0]    res_granted_r, res_granted_nxt;
  status_t          res_status_r, res_status_nxt;
  out_item_t        out_r, out_nxt;

  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [EW-1:0]     eff_cnt;
  logic [XW-1:0]     tgt_idx, start_idx;
  logic [WORD_W-1:0] tmask;
  logic              free_ok, ext_ok, grow;
  logic [RW-1:0]     hw_row;
  logic [SW-1:0]     start_bit;
  logic [WORD_W-1:0] lo_mask, hi_mask, cand, lowest;
  logic [OFS_W-1:0]  pos;
  logic              found, more;

  lfna_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(row_r),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(row_r),
    .rdata(ram_rdata)
  );

  // node count clamped to 1..NODES
  always_comb begin
    if (count_cfg_r == '0) begin
      eff_cnt = EW'(1);
    end else if (EW'(count_cfg_r) > EW'(NODES)) begin
      eff_cnt = EW'(NODES);
    end else begin
      eff_cnt = EW'(count_cfg_r);
    end
  end

  always_comb begin
    if (op_r == OP_FREE) begin
      tgt_idx = XW'(id_r);
    end else if (hmode_r) begin
      tgt_idx = grant_r;
    end else begin
      tgt_idx = hw_r + XW'(1);
    end
  end

  always_comb begin
    if (in_data.opcode == OP_FREE) begin
      start_idx = XW'(in_data.node_id);
    end else if (hint_vld_r) begin
      start_idx = hint_r;
    end else begin
      start_idx = hw_r + XW'(1);
    end
  end

  assign tmask   = WORD_W'(1) << tgt_idx[OFS_W-1:0];
  assign free_ok = (EW'(id_r) < eff_cnt) && ((ram_rdata & tmask) != '0);
  assign ext_ok  = (EW'(hw_r) + EW'(1)) < eff_cnt;
  assign grow    = (grant_r >= hw_r) && ((EW'(hw_r) + EW'(1)) < EW'(NODES));
  assign hw_row  = hw_r[XW-1:OFS_W];

  // scan window: above the grant in the first row, up to the mark
  assign start_bit = first_r ? (SW'(grant_r[OFS_W-1:0]) + SW'(1)) : '0;
  assign lo_mask   = {WORD_W{1'b1}} << start_bit;
  always_comb begin
    if (row_r > hw_row) begin
      hi_mask = '0;
    end else if (row_r == hw_row) begin
      hi_mask = {WORD_W{1'b1}} >> (OFS_W'(WORD_W - 1) - hw_r[OFS_W-1:0]);
    end else begin
      hi_mask = {WORD_W{1'b1}};
    end
  end

  assign cand   = ~ram_rdata & lo_mask & hi_mask;
  assign lowest = cand & (~cand + WORD_W'(1));
  assign found  = |cand;

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        pos = pos | OFS_W'(i);
      end
    end
  end

  assign more         = (op_r == OP_ALLOC) && hmode_r && !found && (row_r < hw_row);
  assign sts.more     = more;
  assign sts.clr_last = (row_r == RW'(ROWS - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | tmask;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_wdata = (row_r == '0) ? WORD_W'(1) : '0;
    end else if (cmd.eval && first_r) begin
      if (op_r == OP_FREE) begin
        ram_we    = free_ok;
        ram_wdata = ram_rdata & ~tmask;
      end else if (hmode_r) begin
        ram_we = 1'b1;
      end else begin
        ram_we = ext_ok;
      end
    end
  end

  always_comb begin
    count_cfg_nxt   = count_cfg_r;
    hw_nxt          = hw_r;
    hint_nxt        = hint_r;
    hint_vld_nxt    = hint_vld_r;
    row_nxt         = row_r;
    first_nxt       = first_r;
    op_nxt          = op_r;
    id_nxt          = id_r;
    hmode_nxt       = hmode_r;
    grant_nxt       = grant_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    out_nxt         = out_r;

    if (cfg_we) begin
      count_cfg_nxt = cfg_data;
    end

    if (cmd.clr_step) begin
      row_nxt = row_r + RW'(1);
    end

    if (cmd.start) begin
      op_nxt    = in_data.opcode;
      id_nxt    = in_data.node_id;
      first_nxt = 1'b1;
      hmode_nxt = hint_vld_r;
      grant_nxt = hint_r;
      row_nxt   = start_idx[XW-1:OFS_W];
    end

    if (cmd.eval) begin
      if (op_r == OP_FREE) begin
        res_granted_nxt = '0;
        if (free_ok) begin
          res_status_nxt = ST_DONE;
          if (!hint_vld_r || (tgt_idx < hint_r)) begin
            hint_nxt     = tgt_idx;
            hint_vld_nxt = 1'b1;
          end
          if ((tgt_idx == hw_r) && (hw_r != '0)) begin
            hw_nxt = hw_r - XW'(1);
          end
        end else begin
          res_status_nxt = ST_IGNORED;
        end
      end else if (!hmode_r) begin
        hint_nxt     = '0;
        hint_vld_nxt = 1'b0;
        if (ext_ok) begin
          hw_nxt          = tgt_idx;
          res_granted_nxt = tgt_idx;
          res_status_nxt  = ST_DONE;
        end else begin
          res_granted_nxt = '0;
          res_status_nxt  = ST_NO_SPACE;
        end
      end else begin
        res_granted_nxt = grant_r;
        res_status_nxt  = ST_DONE;
        first_nxt       = 1'b0;
        if (more) begin
          row_nxt = row_r + RW'(1);
        end else begin
          if (found) begin
            hint_nxt     = {row_r, pos};
            hint_vld_nxt = 1'b1;
          end else begin
            hint_nxt     = '0;
            hint_vld_nxt = 1'b0;
          end
          if (grow) begin
            hw_nxt = hw_r + XW'(1);
          end
        end
      end
    end

    if (cmd.finish) begin
      out_nxt.granted_id = ID_W'(res_granted_r);
      out_nxt.status     = res_status_r;
      out_nxt.top_mark   = ID_W'(hw_r);
      out_nxt.hint_valid = hint_vld_r;
      out_nxt.hint_id    = hint_vld_r ? ID_W'(hint_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_cfg_r  <= CNT_W'(1024);
      hw_r         <= '0;
      hint_r       <= '0;
      hint_vld_r   <= 1'b0;
      row_r        <= '0;
      first_r      <= 1'b0;
    end else begin
      count_cfg_r  <= count_cfg_nxt;
      hw_r         <= hw_nxt;
      hint_r       <= hint_nxt;
      hint_vld_r   <= hint_vld_nxt;
      row_r        <= row_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    id_r          <= id_nxt;
    hmode_r       <= hmode_nxt;
    grant_r       <= grant_nxt;
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_r         <= out_nxt;
  end

  assign out_data = out_r;

endmodule

FILE: design/lfna_ctrl.sv
// Allocator controller: reset sweep, request sequencing, output valid.
// Depends on lfna_pkg.
module lfna_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lfna_pkg::dp_sts_t sts,
  output lfna_pkg::dp_cmd_t cmd
);
  import lfna_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.more ? S_READ : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/lowest_free_node_allocator_core.sv
// Lowest-free node allocator, top level.
// Depends on lfna_pkg, lfna_ctrl, lfna_datapath, lfna_ram and the defines header.
//
// Usage:
// - Input channel (in_valid/in_stall/in_data): one allocate or free request per
//   transaction. Output channel (out_valid/out_stall/out_data): exactly one
//   result per request, in request order.
// - Configuration channel (cfg_valid/cfg_ready/cfg_data): writes the node count.
//   cfg_ready is always high; write only while no request is in flight.
// - Steps: accept, row read, evaluate, output load; out_valid rises with the
//   output register load. An allocate from the hint scans the used bitmap one
//   32-node row at a time (RAM read, then evaluate), from the granted node up
//   to the high-water mark, repeating both steps for each row past the grant row.
// - Flow: one request at a time; the next request is accepted the cycle
//   after the output register is loaded.
// - Reset: a sweep writes every bitmap row (node 0 used, rest free), one row a
//   cycle, all ceil(NODES / 32) rows with in_stall high. Config writes are taken.
// - Output stall: the finished result waits in the output register; a new
//   request is still accepted, and only its own result waits for the register.
`include "lowest_free_node_allocator_core_defines.svh"

module lowest_free_node_allocator_core #(
  parameter int NODES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lfna_pkg::in_item_t         in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output lfna_pkg::out_item_t        out_data,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfna_pkg::CNT_W-1:0] cfg_data
);
  import lfna_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // register write is a single flop load, never blocked
  assign cfg_ready = 1'b1;

  lfna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfna_datapath #(.NODES(NODES)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_data (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .out_data(out_data)
  );

  // one request in flight: the cycle after an accept the input is stalled
  `LFNA_ASSERT_NEXT(a_single_in_flight, in_valid && !in_stall, in_stall, "request accepted while busy")

  // only a successful allocate carries a granted node
  `LFNA_ASSERT_NOW(a_grant_zero, out_valid && (out_data.status != ST_DONE), out_data.granted_id == '0, "nonzero grant on failed request")

  // no hint means hint_id reads as zero
  `LFNA_ASSERT_NOW(a_hint_zero, out_valid && !out_data.hint_valid, out_data.hint_id == '0, "hint id set without hint")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for lowest_free_node_allocator_core.
// Depends on lfna_pkg and the allocator RTL; holds its own allocator predictor,
// drives requests and node count writes, and checks every result in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfna_pkg::*;

  localparam int NODE_TOTAL = 1024;
  localparam int CFG_MAX    = (1 << CNT_W) - 1;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lowest_free_node_allocator_core #(
    .NODES(NODE_TOTAL)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the allocator's used bitmap, lowest-free hint,
  // high-water mark and node count register. The bitmap, hint and mark update
  // once per accepted transaction, in acceptance order; the count on each write.
  // ---------------------------------------------------------------------------
  bit        slot_taken [NODE_TOTAL];
  int        lo_hint;
  bit        lo_hint_ok;
  int        mark;
  int        count_cfg;

  out_item_t results_due[$];  // predicted results not yet seen on the output
  out_item_t last_pred;       // prediction for the most recent request

  int n_errors   = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_cfg      = 0;
  int n_ignored  = 0;
  int n_no_space = 0;
  int peak_mark  = 0;

  // sender pacing
  int gap_max    = 0;
  int burst_left = 1;
  bit req_up     = 1'b0;

  function automatic void reset_allocator_mirror();
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    slot_taken[0] = 1'b1;
    lo_hint       = 0;
    lo_hint_ok    = 1'b0;
    mark          = 0;
    count_cfg     = 1024;
  endfunction

  // node count of 0 behaves as 1, anything past the table as the table size
  function automatic int active_count();
    if (count_cfg == 0) return 1;
    if (count_cfg > NODE_TOTAL) return NODE_TOTAL;
    return count_cfg;
  endfunction

  function automatic out_item_t predict_allocator(in_item_t req);
    out_item_t res;
    int        cnt;
    int        grant;
    int        next_free;
    bit        found;
    status_t   st;
    cnt   = active_count();
    grant = 0;
    st    = ST_DONE;
    if (req.opcode == OP_ALLOC) begin
      if (lo_hint_ok) begin
        // grant the hint, then look upward (bounded by the mark) for the next hole
        grant             = lo_hint;
        slot_taken[grant] = 1'b1;
        found             = 1'b0;
        next_free         = 0;
        for (int i = grant + 1; i <= mark && i < NODE_TOTAL; i++) begin
          if (!slot_taken[i]) begin
            next_free = i;
            found     = 1'b1;
            break;
          end
        end
        if (grant >= mark && mark + 1 < NODE_TOTAL) mark++;
        lo_hint    = found ? next_free : 0;
        lo_hint_ok = found;
      end else begin
        lo_hint = 0;
        if (mark + 1 >= cnt) begin
          st = ST_NO_SPACE;
        end else begin
          mark++;
          slot_taken[mark] = 1'b1;
          grant            = mark;
        end
      end
    end else begin
      if (req.node_id >= cnt || !slot_taken[req.node_id]) begin
        st = ST_IGNORED;
      end else begin
        slot_taken[req.node_id] = 1'b0;
        if (!lo_hint_ok || req.node_id < lo_hint) begin
          lo_hint    = req.node_id;
          lo_hint_ok = 1'b1;
        end
        if (req.node_id == mark && mark > 0) mark--;
      end
    end
    res.granted_id = grant[ID_W-1:0];
    res.status     = st;
    res.top_mark   = mark[ID_W-1:0];
    res.hint_valid = lo_hint_ok;
    res.hint_id    = lo_hint_ok ? lo_hint[ID_W-1:0] : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. in_valid stays up across a burst; it only drops when a gap
  // follows, so valid never reacts to stall and a stalled payload holds still.
  // ---------------------------------------------------------------------------
  task automatic drop_req();
    if (req_up) begin
      in_valid <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  task automatic send_req(op_t op, int id);
    in_item_t req;
    int       gap;
    req.opcode  = op;
    req.node_id = id[ID_W-1:0];
    in_valid <= 1'b1;
    in_data  <= req;
    req_up = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    // transaction accepted at this edge
    last_pred = predict_allocator(req);
    results_due.push_back(last_pred);
    n_sent++;
    if (last_pred.status == ST_IGNORED) n_ignored++;
    if (last_pred.status == ST_NO_SPACE) n_no_space++;
    if (mark > peak_mark) peak_mark = mark;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        drop_req();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // the node count only changes with nothing in flight
  task automatic write_node_count(int value);
    drop_req();
    while (results_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    count_cfg = value & CFG_MAX;
    n_cfg++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        $error("result with nothing outstanding: %p", out_data);
        n_errors++;
      end else begin
        want = results_due.pop_front();
        n_checked++;
        check_field("granted_id", want.granted_id, out_data.granted_id);
        check_field("status", want.status, out_data.status);
        check_field("top_mark", want.top_mark, out_data.top_mark);
        check_field("hint_valid", want.hint_valid, out_data.hint_valid);
        check_field("hint_id", want.hint_id, out_data.hint_id);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output backpressure. The duty cycle changes with each epoch of random length
  // (including epochs with no stall at all); within an epoch the stall comes
  // in runs of random length.
  // ---------------------------------------------------------------------------
  int stall_duty  = 0;
  int stall_run   = 0;
  int stall_epoch = 0;
  bit stall_level = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_epoch == 0) begin
        stall_epoch = $urandom_range(64, 400);
        case ($urandom_range(0, 3))
          0: stall_duty = 0;
          1: stall_duty = 25;
          2: stall_duty = 60;
          default: stall_duty = 90;
        endcase
      end
      stall_epoch--;
      if (stall_run == 0) begin
        stall_run   = $urandom_range(1, (stall_duty >= 60) ? 20 : 4);
        stall_level = ($urandom_range(0, 99) < stall_duty);
      end
      stall_run--;
      out_stall <= stall_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Default count: extension grants, double free, free of a never-used node,
  // regrant of a hole, top free pulling the mark down, free of node zero.
  task automatic test_basic_requests();
    send_req(OP_ALLOC, 0);
    send_req(OP_ALLOC, NODE_TOTAL - 1);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, 2);
    send_req(OP_FREE, 2);                // already free
    send_req(OP_FREE, NODE_TOTAL - 1);   // never allocated
    send_req(OP_ALLOC, 0);               // hint, scan finds nothing
    send_req(OP_FREE, 3);                // top node, mark drops
    send_req(OP_ALLOC, 0);               // hint above mark, mark grows
    send_req(OP_FREE, 0);
    send_req(OP_ALLOC, NODE_TOTAL - 1);
  endtask

  // Register extremes: 0 acts as one node, all ones acts as the full table.
  task automatic test_count_extremes();
    write_node_count(0);
    send_req(OP_ALLOC, 0);               // no space
    send_req(OP_FREE, 1);                // out of range
    send_req(OP_FREE, 0);
    send_req(OP_ALLOC, 0);               // regrant from hint
    send_req(OP_ALLOC, 0);               // no space again
    write_node_count(CFG_MAX);
    send_req(OP_ALLOC, 0);
  endtask

  // Count lowered under a live hint: the hint is still granted.
  task automatic test_count_lowered();
    write_node_count(6);
    send_req(OP_ALLOC, 0);
    send_req(OP_ALLOC, 0);               // reaches the count
    send_req(OP_FREE, 4);
    write_node_count(2);
    send_req(OP_ALLOC, 0);               // hint 4 granted past the count
    send_req(OP_FREE, 5);                // out of range now
    send_req(OP_ALLOC, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------

  // Phases at growing counts, the last one lowered below the mark. Frees mostly
  // hit used nodes (or the top one) so the hint and the mark keep moving.
  task automatic test_random_mix();
    int counts[6];
    int cnt;
    int alloc_pct;
    int id;
    counts[0] = 2;
    counts[1] = $urandom_range(3, 16);
    counts[2] = $urandom_range(17, 64);
    counts[3] = $urandom_range(65, 200);
    counts[4] = $urandom_range(200, 400);
    counts[5] = $urandom_range(8, 40);
    alloc_pct = 50;
    for (int p = 0; p < 6; p++) begin
      gap_max = (p % 2 == 0) ? 8 : 0;
      write_node_count(counts[p]);
      cnt = active_count();
      for (int k = 0; k < 100; k++) begin
        if (k % 20 == 0) begin
          case ($urandom_range(0, 2))
            0: alloc_pct = 25;
            1: alloc_pct = 50;
            default: alloc_pct = 85;
          endcase
        end
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_req(OP_ALLOC, $urandom_range(0, NODE_TOTAL - 1));
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            id = $urandom_range(0, NODE_TOTAL - 1);  // mostly ignored
          end else if (mark < cnt && $urandom_range(0, 3) == 0) begin
            id = mark;
          end else begin
            id = $urandom_range(0, cnt - 1);
            for (int t = 0; t < 8 && !slot_taken[id]; t++) id = $urandom_range(0, cnt - 1);
          end
          send_req(OP_FREE, id);
        end
      end
    end
  endtask

  // Fill the whole table until the mark sits at the last node, then work the
  // top of the table where the mark cannot grow any further.
  task automatic test_table_end();
    gap_max = 0;
    write_node_count(CFG_MAX);
    do send_req(OP_ALLOC, $urandom_range(0, NODE_TOTAL - 1));
    while (last_pred.status != ST_NO_SPACE);
    send_req(OP_FREE, NODE_TOTAL - 1);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, NODE_TOTAL - 2);
    send_req(OP_FREE, NODE_TOTAL - 1);
    send_req(OP_ALLOC, 0);
    send_req(OP_ALLOC, 0);
    send_req(OP_FREE, NODE_TOTAL - 1);
    gap_max = 8;
    for (int k = 0; k < 40; k++) begin
      if ($urandom_range(0, 1) == 0) send_req(OP_ALLOC, $urandom_range(0, NODE_TOTAL - 1));
      else send_req(OP_FREE, $urandom_range(NODE_TOTAL - 40, NODE_TOTAL - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed tests, random tests, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    reset_allocator_mirror();
    gap_max = 3;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_requests();
    test_count_extremes();
    test_count_lowered();
    test_random_mix();
    test_table_end();

    drop_req();
    while (results_due.size() != 0) @(posedge clk);
    // room for a full scan, to catch any stray result
    repeat (80) @(posedge clk);

    $display("tb: %0d requests, %0d results checked, %0d node count writes",
             n_sent, n_checked, n_cfg);
    $display("tb: %0d ignored frees, %0d no-space allocates, mark peaked at %0d",
             n_ignored, n_no_space, peak_mark);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: lowest_free_node_allocator_core.f
+incdir+design
design/lfna_pkg.sv
design/lfna_ram.sv
design/lfna_datapath.sv
design/lfna_ctrl.sv
design/lowest_free_node_allocator_core.sv
dv/tb.sv
